@@ design/tpl_pkg.sv @@
// Shared types and constants for the text pen layout and hit test block.
// No dependencies; used by every module of the block.
package tpl_pkg;

    localparam int PEN_W       = 16;
    localparam int TAB_W       = 12;
    localparam int LINE_W      = 10;
    localparam int CODE_W      = 7;
    localparam int DIST_W      = 17;
    localparam int ADV_FRAC    = 6;
    localparam int DIV_STEPS   = 16;
    localparam int DIV_CNT_W   = 5;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_BEGIN = 2'd1;
    localparam logic [1:0] OP_CHAR  = 2'd2;

    localparam logic [CODE_W-1:0] CODE_TAB     = 7'd9;
    localparam logic [CODE_W-1:0] CODE_NEWLINE = 7'd10;

    localparam logic [PEN_W-1:0] PEN_MAX = 16'hFFFF;

    // configuration register indexes
    localparam logic [1:0] CFG_TAB_STOP = 2'd0;
    localparam logic [1:0] CFG_WRAP     = 2'd1;
    localparam logic [1:0] CFG_LINE     = 2'd2;

    // tab stop default is five character widths of eight pixels
    localparam logic [TAB_W-1:0]  TAB_RESET  = 12'd40;
    localparam logic [PEN_W-1:0]  WRAP_RESET = 16'd0;
    localparam logic [LINE_W-1:0] LINE_RESET = 10'd16;

    typedef struct packed {
        logic capture;   // latch item fields, read advance table, start divider
        logic load;      // write advance table entry
        logic start;     // begin: clear layout state, take target
        logic layout;    // apply glyph, tab or newline and count it
        logic hit;       // hit test and widest update
        logic out_load;  // copy state into output register
    } t_cmd;

    typedef struct packed {
        logic count_full;
        logic is_tab;
        logic div_busy;
    } t_stat;

endpackage

@@ design/tpl_div.sv @@
// Restoring divider, one quotient bit per cycle; only the remainder is kept.
// Depends on tpl_pkg.
module tpl_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [tpl_pkg::PEN_W-1:0]   i_dividend,
    input  logic [tpl_pkg::TAB_W-1:0]   i_divisor,
    output logic                        o_busy,
    output logic [tpl_pkg::TAB_W-1:0]   o_rem
);

    logic [tpl_pkg::DIV_CNT_W-1:0] r_cnt;
    logic [tpl_pkg::PEN_W-1:0]     r_dvd;
    logic [tpl_pkg::TAB_W-1:0]     r_rem;
    logic [tpl_pkg::TAB_W:0]       w_shift;
    logic [tpl_pkg::TAB_W:0]       w_diff;

    assign w_shift = {r_rem, r_dvd[tpl_pkg::PEN_W-1]};
    assign w_diff  = w_shift - {1'b0, i_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= tpl_pkg::DIV_CNT_W'(tpl_pkg::DIV_STEPS);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_rem <= '0;
        end else if (r_cnt != '0) begin
            r_dvd <= {r_dvd[tpl_pkg::PEN_W-2:0], 1'b0};
            // remainder stays below the divisor, so the top bit drops cleanly
            if (w_shift >= {1'b0, i_divisor}) begin
                r_rem <= w_diff[tpl_pkg::TAB_W-1:0];
            end else begin
                r_rem <= w_shift[tpl_pkg::TAB_W-1:0];
            end
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_rem  = r_rem;

endmodule

@@ design/tpl_dp.sv @@
// Datapath: config registers, advance table, pen state, hit test, output register.
// Depends on tpl_pkg and tpl_div.
module tpl_dp #(
    parameter int GLYPH_COUNT = 128,
    parameter int MAX_CHARS   = 4096,
    parameter int IDX_W       = 13
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  tpl_pkg::t_cmd                  i_cmd,
    output tpl_pkg::t_stat                 o_stat,
    input  logic                           i_cfg_we,
    input  logic [1:0]                     i_cfg_index,
    input  logic [tpl_pkg::PEN_W-1:0]      i_cfg_data,
    input  logic [tpl_pkg::CODE_W-1:0]     i_char_code,
    input  logic [tpl_pkg::PEN_W-1:0]      i_advance_value,
    input  logic signed [tpl_pkg::PEN_W-1:0] i_target_x,
    input  logic signed [tpl_pkg::PEN_W-1:0] i_target_y,
    output logic [tpl_pkg::PEN_W-1:0]      o_pen_x,
    output logic [tpl_pkg::PEN_W-1:0]      o_pen_y,
    output logic [tpl_pkg::PEN_W-1:0]      o_widest_x,
    output logic [IDX_W-1:0]               o_nearest_index,
    output logic                           o_hit_found,
    output logic                           o_hit_stopped
);

    localparam int AW = $clog2(GLYPH_COUNT);
    localparam int PW = tpl_pkg::PEN_W;
    localparam int ADV_SHIFT_W = tpl_pkg::ADV_FRAC;

    logic [tpl_pkg::TAB_W-1:0]  r_tab;
    logic [PW-1:0]              r_wrap;
    logic [tpl_pkg::LINE_W-1:0] r_line;

    logic [PW-1:0] r_mem [GLYPH_COUNT];
    logic [PW-1:0] r_adv;
    logic [tpl_pkg::CODE_W-1:0] r_code;

    logic [PW-1:0] r_pen_x, r_pen_y, r_widest;
    logic [IDX_W-1:0] r_count, r_best_idx;
    logic [tpl_pkg::DIST_W-1:0] r_best_dist;
    logic r_best_valid, r_stopped;
    logic signed [PW-1:0] r_tx, r_ty;

    logic [tpl_pkg::TAB_W-1:0] w_tab_eff, w_rem;
    logic w_div_busy;

    logic [PW-ADV_SHIFT_W-1:0] w_adv_px;
    logic [PW:0] w_sum, w_tab_next, w_y_next;
    logic [PW-1:0] w_y_sat;
    logic w_wrap;
    logic [PW-1:0] n_pen_x, n_pen_y;

    logic signed [PW+1:0] w_ty_e, w_py_e, w_pyl_e, w_d;
    logic [tpl_pkg::DIST_W-1:0] w_dist;
    logic w_on_line, w_above;

    // config port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tab  <= tpl_pkg::TAB_RESET;
            r_wrap <= tpl_pkg::WRAP_RESET;
            r_line <= tpl_pkg::LINE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                tpl_pkg::CFG_TAB_STOP: r_tab  <= i_cfg_data[tpl_pkg::TAB_W-1:0];
                tpl_pkg::CFG_WRAP:     r_wrap <= i_cfg_data;
                tpl_pkg::CFG_LINE:     r_line <= i_cfg_data[tpl_pkg::LINE_W-1:0];
                default: ;
            endcase
        end
    end

    // advance table, read data registered
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mem[AW'(i_char_code)] <= i_advance_value;
        end
        if (i_cmd.capture) begin
            r_adv  <= r_mem[AW'(i_char_code)];
            r_code <= i_char_code;
        end
    end

    assign w_tab_eff = (r_tab == '0) ? tpl_pkg::TAB_W'(1) : r_tab;

    tpl_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.capture),
        .i_dividend (r_pen_x),
        .i_divisor  (w_tab_eff),
        .o_busy     (w_div_busy),
        .o_rem      (w_rem)
    );

    // layout arithmetic
    assign w_adv_px   = r_adv[PW-1:ADV_SHIFT_W];
    assign w_sum      = {1'b0, r_pen_x} + {{(ADV_SHIFT_W+1){1'b0}}, w_adv_px};
    assign w_wrap     = (r_wrap != '0) && (w_sum > {1'b0, r_wrap});
    assign w_y_next   = {1'b0, r_pen_y} + {{(PW-tpl_pkg::LINE_W+1){1'b0}}, r_line};
    assign w_y_sat    = w_y_next[PW] ? tpl_pkg::PEN_MAX : w_y_next[PW-1:0];
    // next stop = x - (x mod w) + w
    assign w_tab_next = {1'b0, r_pen_x} - {{(PW-tpl_pkg::TAB_W+1){1'b0}}, w_rem}
                      + {{(PW-tpl_pkg::TAB_W+1){1'b0}}, w_tab_eff};

    always_comb begin
        n_pen_x = r_pen_x;
        n_pen_y = r_pen_y;
        if (r_code == tpl_pkg::CODE_TAB) begin
            n_pen_x = w_tab_next[PW] ? tpl_pkg::PEN_MAX : w_tab_next[PW-1:0];
        end else if (r_code == tpl_pkg::CODE_NEWLINE) begin
            n_pen_x = '0;
            n_pen_y = w_y_sat;
        end else if (w_wrap) begin
            n_pen_x = {{ADV_SHIFT_W{1'b0}}, w_adv_px};
            n_pen_y = w_y_sat;
        end else begin
            n_pen_x = w_sum[PW] ? tpl_pkg::PEN_MAX : w_sum[PW-1:0];
        end
    end

    // hit test arithmetic
    assign w_ty_e    = {{2{r_ty[PW-1]}}, r_ty};
    assign w_py_e    = {2'b00, r_pen_y};
    assign w_pyl_e   = w_py_e + {{(PW-tpl_pkg::LINE_W+2){1'b0}}, r_line};
    assign w_d       = {{2{r_tx[PW-1]}}, r_tx} - {2'b00, r_pen_x};
    assign w_dist    = w_d[PW+1] ? tpl_pkg::DIST_W'(-w_d) : w_d[tpl_pkg::DIST_W-1:0];
    assign w_on_line = (w_ty_e >= w_py_e) && (w_ty_e < w_pyl_e);
    assign w_above   = (w_ty_e < w_py_e);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pen_x      <= '0;
            r_pen_y      <= '0;
            r_widest     <= '0;
            r_count      <= '0;
            r_best_idx   <= '0;
            r_best_dist  <= '0;
            r_best_valid <= 1'b0;
            r_stopped    <= 1'b0;
            r_tx         <= '0;
            r_ty         <= '0;
        end else if (i_cmd.start) begin
            r_pen_x      <= '0;
            r_pen_y      <= '0;
            r_widest     <= '0;
            r_count      <= '0;
            r_best_idx   <= '0;
            r_best_dist  <= '0;
            r_best_valid <= 1'b0;
            r_stopped    <= 1'b0;
            r_tx         <= i_target_x;
            r_ty         <= i_target_y;
        end else if (i_cmd.layout) begin
            r_pen_x <= n_pen_x;
            r_pen_y <= n_pen_y;
            r_count <= r_count + 1'b1;
        end else if (i_cmd.hit) begin
            if (r_pen_x > r_widest) begin
                r_widest <= r_pen_x;
            end
            if (!r_stopped) begin
                if (w_on_line) begin
                    if (!r_best_valid || (w_dist < r_best_dist)) begin
                        r_best_valid <= 1'b1;
                        r_best_dist  <= w_dist;
                        r_best_idx   <= r_count;
                    end
                end else if (w_above) begin
                    r_stopped <= 1'b1;
                end
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_pen_x         <= r_pen_x;
            o_pen_y         <= r_pen_y;
            o_widest_x      <= r_widest;
            o_nearest_index <= r_best_idx;
            o_hit_found     <= r_best_valid;
            o_hit_stopped   <= r_stopped;
        end
    end

    assign o_stat.count_full = (r_count == IDX_W'(MAX_CHARS));
    assign o_stat.is_tab     = (r_code == tpl_pkg::CODE_TAB);
    assign o_stat.div_busy   = w_div_busy;

endmodule

@@ design/tpl_ctrl.sv @@
// Controller state machine: input/output handshakes and datapath sequencing.
// Depends on tpl_pkg.
module tpl_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic [1:0]     i_operation,
    output logic           o_ready,
    output logic           o_valid,
    input  logic           i_ready,
    input  tpl_pkg::t_stat i_stat,
    output tpl_pkg::t_cmd  o_cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_LAY  = 3'd2;
    localparam logic [2:0] ST_HIT  = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;

    logic [2:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       w_accept, w_slot_free;

    assign o_ready     = (r_state == ST_IDLE);
    assign w_accept    = i_valid && o_ready;
    assign w_slot_free = !r_out_valid || i_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    o_cmd.capture = 1'b1;
                    o_cmd.load    = (i_operation == tpl_pkg::OP_LOAD);
                    o_cmd.start   = (i_operation == tpl_pkg::OP_BEGIN);
                    if (i_operation == tpl_pkg::OP_BEGIN) begin
                        n_state = ST_HIT;
                    end else if (i_operation == tpl_pkg::OP_CHAR && !i_stat.count_full) begin
                        n_state = ST_DIV;
                    end else begin
                        n_state = ST_FIN;
                    end
                end
            end
            ST_DIV: begin
                // only a tab waits for the remainder
                if (!i_stat.is_tab || !i_stat.div_busy) begin
                    n_state = ST_LAY;
                end
            end
            ST_LAY: begin
                o_cmd.layout = 1'b1;
                n_state      = ST_HIT;
            end
            ST_HIT: begin
                o_cmd.hit = 1'b1;
                n_state   = ST_FIN;
            end
            ST_FIN: begin
                if (w_slot_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_valid = r_out_valid;

endmodule

@@ design/text_pen_layout_hit_test_core.sv @@
// Text pen layout and hit test core: controller plus datapath; uses tpl_pkg, tpl_ctrl, tpl_dp.
// Path from accept to result valid: load, unused op or full count go straight to output load;
// begin runs the hit test; a glyph or newline runs layout, then hit test; a tab first waits
// for the remainder divider. One item in flight: a new item is taken only once idle again;
// a result still waiting in the output register holds the next item before its output load.
// Sync active-low reset clears pen, hit state, handshakes, config; advance table not cleared.
module text_pen_layout_hit_test_core #(
    parameter int GLYPH_COUNT = 128,
    parameter int MAX_CHARS   = 4096
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [1:0]                       i_operation,
    input  logic [tpl_pkg::CODE_W-1:0]       i_char_code,
    input  logic [tpl_pkg::PEN_W-1:0]        i_advance_value,
    input  logic signed [tpl_pkg::PEN_W-1:0] i_target_x,
    input  logic signed [tpl_pkg::PEN_W-1:0] i_target_y,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [tpl_pkg::PEN_W-1:0]        o_pen_x,
    output logic [tpl_pkg::PEN_W-1:0]        o_pen_y,
    output logic [tpl_pkg::PEN_W-1:0]        o_widest_x,
    output logic [$clog2(MAX_CHARS+1)-1:0]   o_nearest_index,
    output logic                             o_hit_found,
    output logic                             o_hit_stopped,
    input  logic                             i_cfg_we,
    input  logic [1:0]                       i_cfg_index,
    input  logic [tpl_pkg::PEN_W-1:0]        i_cfg_data
);

    localparam int IDX_W = $clog2(MAX_CHARS+1);

    tpl_pkg::t_cmd  w_cmd;
    tpl_pkg::t_stat w_stat;

    tpl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_operation (i_operation),
        .o_ready     (o_ready),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    tpl_dp #(
        .GLYPH_COUNT (GLYPH_COUNT),
        .MAX_CHARS   (MAX_CHARS),
        .IDX_W       (IDX_W)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_char_code     (i_char_code),
        .i_advance_value (i_advance_value),
        .i_target_x      (i_target_x),
        .i_target_y      (i_target_y),
        .o_pen_x         (o_pen_x),
        .o_pen_y         (o_pen_y),
        .o_widest_x      (o_widest_x),
        .o_nearest_index (o_nearest_index),
        .o_hit_found     (o_hit_found),
        .o_hit_stopped   (o_hit_stopped)
    );

endmodule

@@ bench/tb.sv @@
// Self-checking bench for text_pen_layout_hit_test_core: drives layout items over valid/ready
// with random sender bursts and receiver stalls, and predicts each report in the bench itself.
// Depends on tpl_pkg and text_pen_layout_hit_test_core.
module tb;

    localparam int PEN_W       = tpl_pkg::PEN_W;
    localparam int CODE_W      = tpl_pkg::CODE_W;
    localparam int CHAR_LIMIT  = 4096;
    localparam int IDX_W       = $clog2(CHAR_LIMIT + 1);
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct {
        logic [PEN_W-1:0] pen_x;
        logic [PEN_W-1:0] pen_y;
        logic [PEN_W-1:0] widest;
        logic [IDX_W-1:0] nearest;
        logic             found;
        logic             stopped;
    } t_pen_report;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    item_valid = 1'b0;
    logic                    item_ready;
    logic [1:0]              item_op = tpl_pkg::OP_LOAD;
    logic [CODE_W-1:0]       item_code = '0;
    logic [PEN_W-1:0]        item_adv = '0;
    logic signed [PEN_W-1:0] item_tx = '0;
    logic signed [PEN_W-1:0] item_ty = '0;
    logic                    rep_valid;
    logic                    rep_ready = 1'b0;
    logic [PEN_W-1:0]        rep_pen_x;
    logic [PEN_W-1:0]        rep_pen_y;
    logic [PEN_W-1:0]        rep_widest;
    logic [IDX_W-1:0]        rep_nearest;
    logic                    rep_found;
    logic                    rep_stopped;
    logic                    cfg_we = 1'b0;
    logic [1:0]              cfg_index = tpl_pkg::CFG_TAB_STOP;
    logic [PEN_W-1:0]        cfg_data = '0;

    text_pen_layout_hit_test_core #(
        .GLYPH_COUNT(128),
        .MAX_CHARS  (CHAR_LIMIT)
    ) dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_valid        (item_valid),
        .o_ready        (item_ready),
        .i_operation    (item_op),
        .i_char_code    (item_code),
        .i_advance_value(item_adv),
        .i_target_x     (item_tx),
        .i_target_y     (item_ty),
        .o_valid        (rep_valid),
        .i_ready        (rep_ready),
        .o_pen_x        (rep_pen_x),
        .o_pen_y        (rep_pen_y),
        .o_widest_x     (rep_widest),
        .o_nearest_index(rep_nearest),
        .o_hit_found    (rep_found),
        .o_hit_stopped  (rep_stopped),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    initial begin
        forever #6 clk = ~clk;
    end

    // ---------------- layout predictor ----------------
    logic [PEN_W-1:0]  glyph_adv [128];
    bit                glyph_loaded [128];
    int                pen_x_now = 0;
    int                pen_y_now = 0;
    int                widest_now = 0;
    int                chars_laid = 0;
    int                best_pos = 0;
    int                best_gap = 0;
    bit                best_held = 0;
    bit                hit_done = 0;
    logic signed [PEN_W-1:0] aim_x = '0;
    logic signed [PEN_W-1:0] aim_y = '0;
    int                tab_pitch = int'(tpl_pkg::TAB_RESET);
    int                wrap_limit = int'(tpl_pkg::WRAP_RESET);
    int                line_pitch = int'(tpl_pkg::LINE_RESET);

    t_pen_report       pen_reports_q [$];

    int                fault_count = 0;
    int                items_sent = 0;
    int                reports_checked = 0;
    int                reg_writes = 0;
    int                burst_left = 0;
    int                hold_left = 0;
    int                cycle_count = 0;

    function automatic int clip_pen(int v);
        return (v > int'(tpl_pkg::PEN_MAX)) ? int'(tpl_pkg::PEN_MAX) : v;
    endfunction

    function automatic void probe_hit(int idx);
        int ty;
        int tx;
        int d;
        if (hit_done)
            return;
        ty = aim_y;
        tx = aim_x;
        if (ty >= pen_y_now && ty < pen_y_now + line_pitch) begin
            d = tx - pen_x_now;
            if (d < 0)
                d = -d;
            if (!best_held || d < best_gap) begin
                best_held = 1;
                best_gap  = d;
                best_pos  = idx;
            end
        end else if (ty < pen_y_now) begin
            hit_done = 1;
        end
    endfunction

    function automatic void place_code(logic [CODE_W-1:0] code);
        int w;
        int adv;
        if (code == tpl_pkg::CODE_TAB) begin
            w = (tab_pitch == 0) ? 1 : tab_pitch;
            pen_x_now = clip_pen((pen_x_now / w + 1) * w);
        end else if (code == tpl_pkg::CODE_NEWLINE) begin
            pen_x_now = 0;
            pen_y_now = clip_pen(pen_y_now + line_pitch);
        end else begin
            adv = int'(glyph_adv[code] >> tpl_pkg::ADV_FRAC);
            // glyph that would cross the wrap limit starts a new line first
            if (wrap_limit != 0 && pen_x_now + adv > wrap_limit) begin
                pen_x_now = 0;
                pen_y_now = clip_pen(pen_y_now + line_pitch);
            end
            pen_x_now = clip_pen(pen_x_now + adv);
        end
        if (pen_x_now > widest_now)
            widest_now = pen_x_now;
    endfunction

    function automatic void advance_layout(logic [1:0] op, logic [CODE_W-1:0] code,
                                           logic [PEN_W-1:0] adv,
                                           logic signed [PEN_W-1:0] tx,
                                           logic signed [PEN_W-1:0] ty);
        t_pen_report r;
        case (op)
            tpl_pkg::OP_LOAD: begin
                glyph_adv[code]    = adv;
                glyph_loaded[code] = 1;
            end
            tpl_pkg::OP_BEGIN: begin
                pen_x_now  = 0;
                pen_y_now  = 0;
                widest_now = 0;
                chars_laid = 0;
                best_pos   = 0;
                best_gap   = 0;
                best_held  = 0;
                hit_done   = 0;
                aim_x      = tx;
                aim_y      = ty;
                probe_hit(0);
            end
            tpl_pkg::OP_CHAR: begin
                // full count: item ignored, state reported as is
                if (chars_laid < CHAR_LIMIT) begin
                    place_code(code);
                    chars_laid++;
                    probe_hit(chars_laid);
                end
            end
            default: ;
        endcase
        r.pen_x   = PEN_W'(pen_x_now);
        r.pen_y   = PEN_W'(pen_y_now);
        r.widest  = PEN_W'(widest_now);
        r.nearest = IDX_W'(best_pos);
        r.found   = best_held;
        r.stopped = hit_done;
        pen_reports_q.push_back(r);
    endfunction

    // ---------------- report side ----------------
    function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            fault_count++;
            $error("%s: expected %0d, got %0d", field, want, got);
        end
    endfunction

    always @(posedge clk) begin : report_side
        t_pen_report want;
        int          rx_mode;
        int          rx_left;
        if (rep_valid === 1'b1 && rep_ready) begin
            if (pen_reports_q.size() == 0) begin
                fault_count++;
                $error("report with no item pending: pen_x %0d pen_y %0d",
                       rep_pen_x, rep_pen_y);
            end else begin
                want = pen_reports_q.pop_front();
                check_field("pen_x", want.pen_x, rep_pen_x);
                check_field("pen_y", want.pen_y, rep_pen_y);
                check_field("widest_x", want.widest, rep_widest);
                check_field("nearest_index", want.nearest, rep_nearest);
                check_field("hit_found", want.found, rep_found);
                check_field("hit_stopped", want.stopped, rep_stopped);
                reports_checked++;
            end
        end
        if (hold_left > 0) begin
            rep_ready <= 1'b0;
            hold_left--;
        end else begin
            if (rx_left <= 0) begin
                rx_mode = $urandom_range(0, 3);
                rx_left = $urandom_range(20, 200);
            end
            rx_left--;
            case (rx_mode)
                2:       rep_ready <= 1'($urandom_range(0, 1));
                3:       rep_ready <= ($urandom_range(0, 3) == 0);
                default: rep_ready <= 1'b1;
            endcase
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: timeout after %0d cycles", cycle_count);
            $display("tb: done, errors");
            $finish;
        end
    end

    // ---------------- item side ----------------
    task automatic send_item(input logic [1:0] op, input logic [CODE_W-1:0] code,
                             input logic [PEN_W-1:0] adv,
                             input logic signed [PEN_W-1:0] tx,
                             input logic signed [PEN_W-1:0] ty);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            case ($urandom_range(0, 3))
                0:       gap = 0;
                3:       gap = $urandom_range(5, 30);
                default: gap = $urandom_range(1, 4);
            endcase
            if (gap != 0) begin
                item_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        item_valid <= 1'b1;
        item_op    <= op;
        item_code  <= code;
        item_adv   <= adv;
        item_tx    <= tx;
        item_ty    <= ty;
        do @(posedge clk); while (item_ready !== 1'b1);
        advance_layout(op, code, adv, tx, ty);
        items_sent++;
    endtask

    task automatic send_load(input logic [CODE_W-1:0] code, input logic [PEN_W-1:0] adv);
        send_item(tpl_pkg::OP_LOAD, code, adv, PEN_W'($urandom), PEN_W'($urandom));
    endtask

    task automatic send_begin(input logic signed [PEN_W-1:0] tx,
                              input logic signed [PEN_W-1:0] ty);
        send_item(tpl_pkg::OP_BEGIN, CODE_W'($urandom), PEN_W'($urandom), tx, ty);
    endtask

    task automatic send_char(input logic [CODE_W-1:0] code);
        send_item(tpl_pkg::OP_CHAR, code, PEN_W'($urandom), PEN_W'($urandom),
                  PEN_W'($urandom));
    endtask

    // drop valid and let every pending report come back
    task automatic wait_for_reports();
        item_valid <= 1'b0;
        do @(posedge clk); while (pen_reports_q.size() != 0);
    endtask

    task automatic write_reg(input logic [1:0] idx, input int value, input int width);
        // bits above the register width carry junk; the register keeps the low bits
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= PEN_W'(value) | (PEN_W'($urandom) << width);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        reg_writes++;
    endtask

    task automatic set_config(input int tab, input int wrap, input int line);
        wait_for_reports();
        write_reg(tpl_pkg::CFG_TAB_STOP, tab, tpl_pkg::TAB_W);
        write_reg(tpl_pkg::CFG_WRAP, wrap, PEN_W);
        write_reg(tpl_pkg::CFG_LINE, line, tpl_pkg::LINE_W);
        tab_pitch  = tab;
        wrap_limit = wrap;
        line_pitch = line;
    endtask

    function automatic logic [PEN_W-1:0] pick_advance();
        if ($urandom_range(0, 9) == 0)
            return PEN_W'($urandom);
        return PEN_W'(($urandom_range(0, 24) << tpl_pkg::ADV_FRAC) | $urandom_range(0, 63));
    endfunction

    function automatic logic [CODE_W-1:0] pick_glyph();
        logic [CODE_W-1:0] c;
        do
            c = CODE_W'($urandom_range(0, 127));
        while (c == tpl_pkg::CODE_TAB || c == tpl_pkg::CODE_NEWLINE || !glyph_loaded[c]);
        return c;
    endfunction

    task automatic send_text_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            send_char(pick_glyph());
        else if (r < 82)
            send_char(tpl_pkg::CODE_TAB);
        else if (r < 92)
            send_char(tpl_pkg::CODE_NEWLINE);
        else if (r < 95)
            send_load(CODE_W'($urandom_range(0, 127)), pick_advance());
        else if (r < 97)
            send_item(OP_UNUSED, CODE_W'($urandom), PEN_W'($urandom),
                      PEN_W'($urandom), PEN_W'($urandom));
        else
            send_begin(PEN_W'($urandom), PEN_W'($urandom));
    endtask

    task automatic lay_random_paragraph(input int n_chars);
        int tx;
        int ty;
        case ($urandom_range(0, 7))
            0: begin
                tx = $signed(PEN_W'($urandom));
                ty = $signed(PEN_W'($urandom));
            end
            1: begin
                tx = int'($urandom_range(0, 700)) - 20;
                ty = -int'($urandom_range(1, 50));
            end
            default: begin
                tx = int'($urandom_range(0, 700)) - 20;
                ty = int'($urandom_range(0, 5)) * line_pitch
                   + int'($urandom_range(0, line_pitch - 1));
            end
        endcase
        send_begin(PEN_W'(tx), PEN_W'(ty));
        repeat (n_chars) send_text_char();
    endtask

    // ---------------- tests ----------------
    // reset settings, characters laid out before any begin item
    task automatic test_before_begin();
        send_load(7'd65, 16'd512);
        send_load(7'd127, 16'hFFFF);
        send_load(7'd0, 16'd0);
        send_load(7'd32, 16'd383);
        send_char(7'd65);
        send_char(tpl_pkg::CODE_TAB);
        send_char(7'd0);
        send_item(OP_UNUSED, tpl_pkg::CODE_NEWLINE, 16'hFFFF, 16'sh7FFF, -16'sd1);
        send_char(tpl_pkg::CODE_NEWLINE);
        send_char(7'd127);
        send_char(7'd32);
    endtask

    task automatic test_hit_window();
        send_begin(16'sd0, -16'sd1);          // target above text: stops at once
        send_char(7'd65);
        send_begin(-16'sd32768, 16'sd32767);
        send_char(7'd127);
        send_char(7'd127);
        send_begin(16'sd32767, 16'sd15);      // bottom row of first line
        send_char(7'd127);
        send_char(tpl_pkg::CODE_TAB);
        send_char(tpl_pkg::CODE_NEWLINE);
        send_begin(16'sd20, 16'sd16);         // second line, equal distances keep first
        repeat (3) send_char(7'd65);
        send_char(tpl_pkg::CODE_NEWLINE);
        repeat (3) send_char(7'd65);
        send_char(tpl_pkg::CODE_NEWLINE);
    endtask

    task automatic test_table_fill();
        for (int c = 0; c < 128; c++)
            send_load(CODE_W'(c), pick_advance());
    endtask

    task automatic test_pen_saturation();
        set_config(40, 0, 1023);
        send_load(7'd127, 16'hFFFF);
        send_begin(16'sd100, 16'sd2000);
        repeat (66) send_char(7'd127);
        send_char(tpl_pkg::CODE_TAB);
        repeat (66) send_char(tpl_pkg::CODE_NEWLINE);
        send_char(7'd127);
        send_char(tpl_pkg::CODE_TAB);
    endtask

    task automatic test_config_sweep();
        int tab;
        int wrap;
        int line;
        int start;
        for (int k = 0; k < 8; k++) begin
            case (k)
                0: begin tab = 1;    wrap = 0;     line = 1;    end
                1: begin tab = 4095; wrap = 65535; line = 1023; end
                2: begin tab = 0;    wrap = 300;   line = 16;   end
                3: begin tab = 40;   wrap = 1;     line = 8;    end
                default: begin
                    tab  = $urandom_range(1, 4095);
                    line = $urandom_range(1, 1023);
                    case ($urandom_range(0, 2))
                        0:       wrap = 0;
                        1:       wrap = $urandom_range(50, 2000);
                        default: wrap = $urandom_range(2000, 65535);
                    endcase
                end
            endcase
            set_config(tab, wrap, line);
            start = items_sent;
            while (items_sent - start < 130)
                lay_random_paragraph($urandom_range(1, 40));
        end
    endtask

    // receiver holds off while items keep coming, so the input backs up
    task automatic test_stalled_output();
        wait_for_reports();
        hold_left = 400;
        lay_random_paragraph(40);
    endtask

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_before_begin();
        test_hit_window();
        test_table_fill();
        test_pen_saturation();
        test_config_sweep();
        test_stalled_output();
        wait_for_reports();
        repeat (30) @(posedge clk);
        $display("tb: %0d items sent, %0d reports checked, %0d register writes",
                 items_sent, reports_checked, reg_writes);
        $display("tb: covered tabs, newlines, wrap, hit window, saturation, config sweep, stalls");
        if (fault_count == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
